// ----- src/dgpw_pkg.sv -----
// ----------------------------------------------------------------------------
// dgpw_pkg
// Shared constants, types and lookup functions for the digit glyph pixel
// writer: the 3x5 font, matrix geometry and the two-panel LED mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package dgpw_pkg;

    localparam int MatrixColumns = 16;
    localparam int MatrixRows    = 8;
    localparam int GlyphCount    = 11;
    localparam int GlyphRows     = 5;
    localparam int GlyphCols     = 3;
    localparam int GlyphPixels   = GlyphRows * GlyphCols;
    localparam int PanelWidth    = 8;
    localparam int PanelLeds     = 64;

    localparam int CoordW  = 6;
    localparam int CodeW   = 4;
    localparam int ColourW = 24;
    localparam int IndexW  = 7;
    localparam int SlotW   = $clog2(GlyphPixels);
    localparam int GRowW   = $clog2(GlyphRows);
    localparam int GColW   = $clog2(GlyphCols);
    localparam int ColW    = $clog2(MatrixColumns);
    localparam int RowW    = (MatrixRows > 1) ? $clog2(MatrixRows) : 1;

    localparam int InFieldsW   = 2 * CoordW + CodeW + ColourW;
    localparam int InTdataW    = ((InFieldsW + 7) / 8) * 8;
    localparam int OutFieldsW  = IndexW + ColourW;
    localparam int OutTdataW   = ((OutFieldsW + 7) / 8) * 8;

    typedef logic [GlyphPixels-1:0] t_mask;
    typedef logic [GlyphCols-1:0]   t_font_row;

    // One pixel write handed from the scan stage to the output register.
    typedef struct packed {
        logic              valid;
        logic [IndexW-1:0] led_index;
        logic [ColourW-1:0] colour;
        logic              last;
    } t_write;

    // Column 0 of a glyph is bit 2 of its row, column 2 is bit 0.
    localparam t_font_row FONT [GlyphCount][GlyphRows] = '{
        '{3'h7, 3'h5, 3'h5, 3'h5, 3'h7},
        '{3'h1, 3'h1, 3'h1, 3'h1, 3'h1},
        '{3'h7, 3'h1, 3'h7, 3'h4, 3'h7},
        '{3'h7, 3'h1, 3'h7, 3'h1, 3'h7},
        '{3'h5, 3'h5, 3'h7, 3'h1, 3'h1},
        '{3'h7, 3'h4, 3'h7, 3'h1, 3'h7},
        '{3'h7, 3'h4, 3'h7, 3'h5, 3'h7},
        '{3'h7, 3'h1, 3'h1, 3'h1, 3'h1},
        '{3'h7, 3'h5, 3'h7, 3'h5, 3'h7},
        '{3'h7, 3'h5, 3'h7, 3'h1, 3'h7},
        '{3'h0, 3'h0, 3'h7, 3'h0, 3'h0}
    };

    // Scan slot k covers glyph row k / 3 and column k % 3.
    function automatic logic [GRowW-1:0] slot_row(input logic [SlotW-1:0] slot);
        logic [GRowW-1:0] row;
        row = '0;
        for (int k = 0; k < GlyphPixels; k++) begin
            if (slot == SlotW'(k)) begin
                row = GRowW'(k / GlyphCols);
            end
        end
        return row;
    endfunction

    function automatic logic [GColW-1:0] slot_col(input logic [SlotW-1:0] slot);
        logic [GColW-1:0] col;
        col = '0;
        for (int k = 0; k < GlyphPixels; k++) begin
            if (slot == SlotW'(k)) begin
                col = GColW'(k % GlyphCols);
            end
        end
        return col;
    endfunction

    // Two 8-column panels side by side; the right panel follows the left.
    function automatic logic [IndexW-1:0] led_map(input logic [ColW-1:0] px,
                                                  input logic [RowW-1:0] py);
        logic [IndexW:0] base;
        base = (IndexW+1)'(py) * (IndexW+1)'(PanelWidth);
        if (px < ColW'(PanelWidth)) begin
            return IndexW'(base + (IndexW+1)'(px));
        end else begin
            return IndexW'(base + (IndexW+1)'(PanelLeds) + (IndexW+1)'(px)
                           - (IndexW+1)'(PanelWidth));
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/digit_glyph_pixel_writer.sv -----
// ----------------------------------------------------------------------------
// digit_glyph_pixel_writer
// Expands a draw-digit request into framebuffer writes for a two-panel
// 16x8 LED matrix using a fixed 3x5 font.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request per beat: glyph origin, glyph code
//   and colour. The master channel gives one framebuffer write per beat,
//   LED index and colour, with tlast on the final write of the request.
//   Lit pixels go out row by row from the top, left to right within a row;
//   pixels off the matrix are dropped. Codes 11 to 15 and requests whose
//   pixels all fall off the matrix produce no beats at all.
//   The request is stored in the input register, and each write then passes
//   through the output register. Throughput: one write per cycle while the
//   master side does not stall; a request holds the slave channel until its
//   scan mask in the input register is empty, and the next request is taken
//   in the cycle the last write of the current one moves into the output
//   register.
//   A stalled master side holds its beat; the scan waits, and tready on
//   the slave side falls until the remaining writes can move on.
//   Reset empties the scan mask and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module digit_glyph_pixel_writer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // i_s_tdata: x_pos[5:0], y_pos[11:6], digit_code[15:12], pixel_colour[39:16]
    input  wire logic [dgpw_pkg::InTdataW-1:0]  i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // o_m_tdata: led_index[6:0], led_colour[30:7], zero pad[31]
    output logic [dgpw_pkg::OutTdataW-1:0]      o_m_tdata,
    output logic                                o_m_tlast
);
    import dgpw_pkg::*;

    t_write write_bus;
    logic   out_take;

    dgpw_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_out_take (out_take),
        .o_write    (write_bus)
    );

    dgpw_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_write    (write_bus),
        .o_take     (out_take),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ----- src/dgpw_scan.sv -----
// ----------------------------------------------------------------------------
// dgpw_scan
// Input register and pixel scan. On accept it stores the request and a mask
// of lit on-matrix pixels; it emits the lowest each cycle the output takes.
// ----------------------------------------------------------------------------
`default_nettype none

module dgpw_scan (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [dgpw_pkg::InTdataW-1:0] i_s_tdata,
    input  wire logic                          i_out_take,
    output dgpw_pkg::t_write                   o_write
);
    import dgpw_pkg::*;

    logic [CoordW-1:0]  in_x;
    logic [CoordW-1:0]  in_y;
    logic [CodeW-1:0]   in_code;
    t_mask              n_mask;

    t_mask              r_mask;
    logic [CoordW-1:0]  r_x;
    logic [CoordW-1:0]  r_y;
    logic [ColourW-1:0] r_colour;

    t_mask              low_bit;
    t_mask              rest;
    logic [SlotW-1:0]   slot;
    logic [GRowW-1:0]   row;
    logic [GColW-1:0]   col;
    logic [CoordW-1:0]  px_full;
    logic [CoordW-1:0]  py_full;
    logic               emit;
    logic               accept;

    assign in_x    = i_s_tdata[CoordW-1:0];
    assign in_y    = i_s_tdata[2*CoordW-1:CoordW];
    assign in_code = i_s_tdata[2*CoordW+CodeW-1:2*CoordW];

    // Visibility mask of the incoming glyph, one bit per scan slot.
    always_comb begin
        logic signed [CoordW:0] sx;
        logic signed [CoordW:0] sy;
        logic                   lit;
        n_mask = '0;
        for (int r = 0; r < GlyphRows; r++) begin
            for (int c = 0; c < GlyphCols; c++) begin
                sx = $signed({in_x[CoordW-1], in_x}) + $signed((CoordW+1)'(c));
                sy = $signed({in_y[CoordW-1], in_y}) + $signed((CoordW+1)'(r));
                lit = 1'b0;
                if (in_code < CodeW'(GlyphCount)) begin
                    lit = FONT[in_code][r][GlyphCols-1-c];
                end
                n_mask[r*GlyphCols+c] = lit
                    && (sx >= 0) && (sx < $signed((CoordW+1)'(MatrixColumns)))
                    && (sy >= 0) && (sy < $signed((CoordW+1)'(MatrixRows)));
            end
        end
    end

    assign low_bit = r_mask & (~r_mask + t_mask'(1));
    assign rest    = r_mask & ~low_bit;

    always_comb begin
        slot = '0;
        for (int k = 0; k < GlyphPixels; k++) begin
            if (low_bit[k]) begin
                slot = slot | SlotW'(k);
            end
        end
    end

    assign row     = slot_row(slot);
    assign col     = slot_col(slot);
    assign px_full = r_x + CoordW'(col);
    assign py_full = r_y + CoordW'(row);

    assign emit       = (r_mask != '0) && i_out_take;
    assign o_s_tready = (r_mask == '0) || (emit && (rest == '0));
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_write.valid     = emit;
        o_write.led_index = led_map(px_full[ColW-1:0], py_full[RowW-1:0]);
        o_write.colour    = r_colour;
        o_write.last      = (rest == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (accept) begin
            r_mask <= n_mask;
        end else if (emit) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x      <= in_x;
            r_y      <= in_y;
            r_colour <= i_s_tdata[InFieldsW-1:2*CoordW+CodeW];
        end
    end

endmodule

`default_nettype wire

// ----- src/dgpw_out_reg.sv -----
// ----------------------------------------------------------------------------
// dgpw_out_reg
// Output register on the master side. It holds one pixel write and loads
// the next one whenever it is empty or its beat is being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dgpw_out_reg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire dgpw_pkg::t_write               i_write,
    output logic                                o_take,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [dgpw_pkg::OutTdataW-1:0]      o_m_tdata,
    output logic                                o_m_tlast
);
    import dgpw_pkg::*;

    logic               r_valid;
    logic [IndexW-1:0]  r_index;
    logic [ColourW-1:0] r_colour;
    logic               r_last;

    assign o_take     = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = OutTdataW'({r_colour, r_index});
    assign o_m_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_write.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_write.valid) begin
            r_index  <= i_write.led_index;
            r_colour <= i_write.colour;
            r_last   <= i_write.last;
        end
    end

endmodule

`default_nettype wire

// ----- src/dgpw_checker.sv -----
// ----------------------------------------------------------------------------
// dgpw_checker
// Port-level checks for the digit glyph pixel writer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dgpw_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           o_s_tready,
    input  wire logic                           o_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic [dgpw_pkg::OutTdataW-1:0] o_m_tdata,
    input  wire logic                           o_m_tlast
);
    import dgpw_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled beat holds its data.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast))
        else $error("stalled beat changed");

    // Writes of one glyph follow each other without a gap.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("gap inside a glyph");

    // While a glyph is still being written and the output stalls,
    // no new request is taken.
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast && !i_m_tready |-> !o_s_tready)
        else $error("request taken while glyph unfinished");

    // The pad bit above the colour stays zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[OutTdataW-1:OutFieldsW] == '0)
        else $error("nonzero pad bits");

endmodule

bind digit_glyph_pixel_writer dgpw_checker u_dgpw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

// ----- sim/digit_glyph_pixel_writer_test.sv -----
// ----------------------------------------------------------------------------
// digit_glyph_pixel_writer_test
// Self-checking testbench for the digit glyph pixel writer. Draw requests are
// fed into the slave stream. Each accepted request is expanded here into its
// expected pixel writes, using a private copy of the 3x5 font and the
// two-panel index map. Every write on the master stream is compared with the
// oldest expected write. Both streams idle and stall at random.
// ----------------------------------------------------------------------------

module digit_glyph_pixel_writer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] GLYPH_MINUS = 4'd10;

    typedef struct {
        logic [6:0]  led_index;
        logic [23:0] led_colour;
        logic        last_write;
    } pixel_write_t;

    class pixel_write_scoreboard;
        pixel_write_t writes_due[$];
        int           errors;
        int           requests_taken;
        int           writes_checked;

        // Rows packed top first, three bits per row, leftmost column highest.
        function automatic logic [14:0] glyph_mask(logic [3:0] code);
            case (code)
                4'd0:        return 15'b111_101_101_101_111;
                4'd1:        return 15'b001_001_001_001_001;
                4'd2:        return 15'b111_001_111_100_111;
                4'd3:        return 15'b111_001_111_001_111;
                4'd4:        return 15'b101_101_111_001_001;
                4'd5:        return 15'b111_100_111_001_111;
                4'd6:        return 15'b111_100_111_101_111;
                4'd7:        return 15'b111_001_001_001_001;
                4'd8:        return 15'b111_101_111_101_111;
                4'd9:        return 15'b111_101_111_001_111;
                GLYPH_MINUS: return 15'b000_000_111_000_000;
                default:     return 15'b0;
            endcase
        endfunction

        // Expand one accepted request into the writes it must produce.
        function automatic void take_request(logic signed [5:0] x_pos,
                                             logic signed [5:0] y_pos,
                                             logic [3:0] digit_code,
                                             logic [23:0] pixel_colour);
            logic [14:0]  mask;
            int           px;
            int           py;
            int           first;
            int           led;
            pixel_write_t wr;
            mask = glyph_mask(digit_code);
            first = writes_due.size();
            requests_taken++;
            for (int r = 0; r < 5; r++) begin
                for (int c = 0; c < 3; c++) begin
                    px = int'(x_pos) + c;
                    py = int'(y_pos) + r;
                    if (mask[14 - 3 * r - c] && px >= 0 && px < 16 && py >= 0 && py < 8) begin
                        led = (px < 8) ? py * 8 + px : 64 + py * 8 + (px - 8);
                        wr.led_index  = led[6:0];
                        wr.led_colour = pixel_colour;
                        wr.last_write = 1'b0;
                        writes_due.push_back(wr);
                    end
                end
            end
            if (writes_due.size() > first) begin
                writes_due[writes_due.size() - 1].last_write = 1'b1;
            end
        endfunction

        function automatic void check_write(logic [6:0] led_index, logic [23:0] led_colour,
                                            logic last_write);
            pixel_write_t exp_wr;
            writes_checked++;
            if (writes_due.size() == 0) begin
                $error("unexpected write: led_index %0d, led_colour %06h, last_write %0b",
                       led_index, led_colour, last_write);
                errors++;
                return;
            end
            exp_wr = writes_due.pop_front();
            if (led_index !== exp_wr.led_index) begin
                $error("led_index expected %0d, got %0d", exp_wr.led_index, led_index);
                errors++;
            end
            if (led_colour !== exp_wr.led_colour) begin
                $error("led_colour expected %06h, got %06h", exp_wr.led_colour, led_colour);
                errors++;
            end
            if (last_write !== exp_wr.last_write) begin
                $error("last_write expected %0b, got %0b", exp_wr.last_write, last_write);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // i_s_tdata: x_pos[5:0], y_pos[11:6], digit_code[15:12], pixel_colour[39:16]
    logic [dgpw_pkg::InTdataW-1:0]  i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // o_m_tdata: led_index[6:0], led_colour[30:7], zero pad[31]
    logic [dgpw_pkg::OutTdataW-1:0] o_m_tdata;
    logic        o_m_tlast;

    int source_idle_pct = 19;
    int sink_stall_pct = 19;

    pixel_write_scoreboard board = new();

    digit_glyph_pixel_writer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Sink side: values read here are the ones present before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                board.check_write(o_m_tdata[6:0], o_m_tdata[30:7], o_m_tlast);
            end
            i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_request(input logic signed [5:0] x_pos, input logic signed [5:0] y_pos,
                                input logic [3:0] digit_code, input logic [23:0] pixel_colour);
        while ($urandom_range(99) < source_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= dgpw_pkg::InTdataW'({$urandom, $urandom});
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pixel_colour, digit_code, y_pos, x_pos};
        do @(posedge i_clk); while (!o_s_tready);
        board.take_request(x_pos, y_pos, digit_code, pixel_colour);
    endtask

    initial begin
        int xi;
        int yi;
        logic [3:0] code;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every glyph fully on the matrix, a few straddling the panel seam.
        send_request(6'sd0, 6'sd0, 4'd0, 24'h000000);
        send_request(6'sd13, 6'sd3, 4'd1, 24'hFFFFFF);
        send_request(6'sd6, 6'sd2, 4'd2, 24'hA5A5A5);
        send_request(6'sd7, 6'sd0, 4'd3, 24'h5A5A5A);
        send_request(6'sd9, 6'sd1, 4'd4, 24'h123456);
        send_request(6'sd2, 6'sd3, 4'd5, 24'hFEDCBA);
        send_request(6'sd10, 6'sd2, 4'd6, 24'h800001);
        send_request(6'sd4, 6'sd1, 4'd7, 24'h7FFFFE);
        send_request(6'sd12, 6'sd0, 4'd8, 24'h00FF00);
        send_request(6'sd1, 6'sd2, 4'd9, 24'hFF00FF);
        send_request(6'sd5, 6'sd3, GLYPH_MINUS, 24'h0F0F0F);
        // Unused codes produce nothing.
        for (int k = dgpw_pkg::GlyphCount; k < 16; k++) begin
            send_request(6'sd3, 6'sd1, 4'(k), 24'hFFFFFF);
        end
        // Clipping on every edge, full clipping, and the far corner LED.
        send_request(-6'sd32, -6'sd32, 4'd8, 24'h111111);
        send_request(6'sd31, 6'sd31, 4'd8, 24'h222222);
        send_request(-6'sd2, 6'sd1, 4'd8, 24'h333333);
        send_request(6'sd14, 6'sd2, 4'd0, 24'h444444);
        send_request(-6'sd3, -6'sd4, 4'd8, 24'h555555);
        send_request(6'sd4, -6'sd4, 4'd8, 24'h666666);
        send_request(6'sd3, 6'sd6, 4'd0, 24'h777777);
        send_request(6'sd15, 6'sd7, 4'd8, 24'h888888);
        send_request(-6'sd1, 6'sd5, GLYPH_MINUS, 24'h999999);

        for (int i = 0; i < 125; i++) begin
            // A middle stretch runs with neither side idling.
            source_idle_pct = (i >= 60 && i < 100) ? 0 : 19;
            sink_stall_pct  = source_idle_pct;
            if ($urandom_range(99) < 80) begin
                xi = int'($urandom_range(18)) - 3;
                yi = int'($urandom_range(12)) - 4;
                code = 4'($urandom_range(10));
            end else begin
                xi = int'($urandom_range(63)) - 32;
                yi = int'($urandom_range(63)) - 32;
                code = 4'($urandom_range(15));
            end
            send_request(6'(xi), 6'(yi), code, 24'($urandom));
        end
        i_s_tvalid <= 1'b0;

        while (board.writes_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Drew %0d requests (all glyph codes, edge clipping, unused codes, stalls).",
                 board.requests_taken);
        $display("Compared %0d pixel writes against the expanded font.", board.writes_checked);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #200_000;
        $display("Timed out with %0d writes outstanding.", board.writes_due.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- digit_glyph_pixel_writer.f -----
src/dgpw_pkg.sv
src/dgpw_scan.sv
src/dgpw_out_reg.sv
src/digit_glyph_pixel_writer.sv
src/dgpw_checker.sv
sim/digit_glyph_pixel_writer_test.sv
